[sv/mtbc_pkg.sv]
`default_nettype none
package mtbc_pkg;

    // Sizing of the name stack
    localparam int MAX_NAME    = 32;
    localparam int STACK_DEPTH = 64;

    localparam int LEN_W  = $clog2(MAX_NAME + 1);
    localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int POS_W  = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
    localparam int CHAR_N = STACK_DEPTH * MAX_NAME;
    localparam int ADDR_W = (CHAR_N > 1) ? $clog2(CHAR_N) : 1;

    // Characters with a meaning to the parser
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Result codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_UNCLOSED = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;

    typedef enum logic [1:0] {
        PH_OUTSIDE,
        PH_OPENED,
        PH_NAME,
        PH_ATTR
    } t_phase;

endpackage
`default_nettype wire

[sv/markup_tag_balance_checker_top.sv]
// Result: the result for a request marked last is registered and presented in the cycle after acceptance.
// Throughput: one byte per cycle while o_in_stall is low; name characters and lengths sit in two synchronous
// memories whose next address is formed from the next state, so the top entry is ready
// when the byte that needs it arrives.
// Reset: i_rst_n (synchronous, active low) clears parser and stack pointer at once;
// memory contents are not cleared and need no clearing pass.
`default_nettype none
module markup_tag_balance_checker_top
    import mtbc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_status,
    output logic [6:0]      o_open_count
);

    localparam logic [ADDR_W-1:0] CHAR_STRIDE = ADDR_W'(MAX_NAME);

    // Memories
    logic [7:0]       mem_chars [CHAR_N];
    logic [LEN_W-1:0] mem_lens  [STACK_DEPTH];

    // Parser and stack registers
    t_phase           r_phase,   n_phase;
    logic [LEN_W-1:0] r_len,     n_len;
    logic             r_closing, n_closing;
    logic             r_mis,     n_mis;
    logic [2:0]       r_err,     n_err;
    logic [PTR_W-1:0] r_sp,      n_sp;

    // Result register
    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_status,    n_status;
    logic [6:0]       r_count,     n_count;

    // Registered memory read data for the top entry
    logic [7:0]       r_char_rd;
    logic [LEN_W-1:0] r_len_rd;

    // Step values before the end-of-document clear
    t_phase           st_phase;
    logic [LEN_W-1:0] st_len;
    logic             st_closing;
    logic             st_mis;
    logic [2:0]       st_err;
    logic [PTR_W-1:0] st_sp;

    logic              in_accept;
    logic              is_letter;
    logic              wr_char_en;
    logic [ADDR_W-1:0] wr_char_addr;
    logic              wr_len_en;
    logic [IDX_W-1:0]  wr_len_idx;
    logic [IDX_W-1:0]  rd_top;
    logic [POS_W-1:0]  rd_pos;
    logic [ADDR_W-1:0] rd_char_addr;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign is_letter  = ((i_ch >= 8'h41) && (i_ch <= 8'h5A)) ||
                        ((i_ch >= 8'h61) && (i_ch <= 8'h7A));

    assign wr_char_addr = ADDR_W'(IDX_W'(r_sp)) * CHAR_STRIDE + ADDR_W'(POS_W'(r_len));
    assign wr_len_idx   = IDX_W'(r_sp);

    // Advance the parser by one byte
    always_comb begin
        logic do_letter;
        logic do_finish;
        do_letter  = 1'b0;
        do_finish  = 1'b0;
        st_phase   = r_phase;
        st_len     = r_len;
        st_closing = r_closing;
        st_mis     = r_mis;
        st_err     = r_err;
        st_sp      = r_sp;
        wr_char_en = 1'b0;
        wr_len_en  = 1'b0;

        if (in_accept && (r_err == ST_OK)) begin
            case (r_phase)
                PH_OUTSIDE: begin
                    if (i_ch == CH_LT) begin
                        st_phase   = PH_OPENED;
                        st_len     = '0;
                        st_closing = 1'b0;
                        st_mis     = 1'b0;
                    end
                end
                PH_OPENED, PH_NAME: begin
                    if ((r_phase == PH_OPENED) && (i_ch == CH_SLASH)) begin
                        st_closing = 1'b1;
                        st_phase   = PH_NAME;
                    end else begin
                        st_phase = PH_NAME;
                        if (is_letter) begin
                            do_letter = 1'b1;
                        end else if (i_ch == CH_SPACE) begin
                            st_phase = PH_ATTR;
                        end else if (i_ch == CH_GT) begin
                            do_finish = 1'b1;
                        end
                    end
                end
                PH_ATTR: begin
                    if (i_ch == CH_GT) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    st_phase = PH_OUTSIDE;
                end
            endcase
        end

        // Collect or compare one name letter
        if (do_letter) begin
            if (r_len >= LEN_W'(MAX_NAME)) begin
                st_err = ST_TOO_LONG;
            end else begin
                if (r_closing) begin
                    if ((r_sp != '0) && (r_sp <= PTR_W'(STACK_DEPTH))) begin
                        if (!((r_len < r_len_rd) && (r_char_rd == i_ch))) begin
                            st_mis = 1'b1;
                        end
                    end
                end else if (r_sp < PTR_W'(STACK_DEPTH)) begin
                    wr_char_en = 1'b1;
                end
                st_len = r_len + 1'b1;
            end
        end

        // Push or pop at the closing bracket
        if (do_finish) begin
            st_phase = PH_OUTSIDE;
            if (r_closing) begin
                if ((r_sp == '0) || (r_sp > PTR_W'(STACK_DEPTH))) begin
                    st_err = ST_EMPTY;
                end else if (r_mis || (r_len != r_len_rd)) begin
                    st_err = ST_MISMATCH;
                end else begin
                    st_sp = r_sp - 1'b1;
                end
            end else begin
                if (r_sp >= PTR_W'(STACK_DEPTH)) begin
                    st_err = ST_OVERFLOW;
                end else begin
                    wr_len_en = 1'b1;
                    st_sp     = r_sp + 1'b1;
                end
            end
        end
    end

    // Next state: clear everything after the final byte
    always_comb begin
        n_phase   = st_phase;
        n_len     = st_len;
        n_closing = st_closing;
        n_mis     = st_mis;
        n_err     = st_err;
        n_sp      = st_sp;
        if (in_accept && i_last) begin
            n_phase   = PH_OUTSIDE;
            n_len     = '0;
            n_closing = 1'b0;
            n_mis     = 1'b0;
            n_err     = ST_OK;
            n_sp      = '0;
        end
    end

    // Result register: load on the final byte, drop when taken
    always_comb begin
        n_out_valid = r_out_valid & i_out_stall;
        n_status    = r_status;
        n_count     = r_count;
        if (in_accept && i_last) begin
            n_out_valid = 1'b1;
            n_count     = 7'(st_sp);
            if ((st_err == ST_OK) && (st_sp != '0)) begin
                n_status = ST_UNCLOSED;
            end else begin
                n_status = st_err;
            end
        end
    end

    // Address the top entry as it will stand for the next byte
    always_comb begin
        rd_top = '0;
        rd_pos = '0;
        if (n_sp != '0) begin
            rd_top = IDX_W'(n_sp - 1'b1);
        end
        if (n_len < LEN_W'(MAX_NAME)) begin
            rd_pos = POS_W'(n_len);
        end
        rd_char_addr = ADDR_W'(rd_top) * CHAR_STRIDE + ADDR_W'(rd_pos);
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OUTSIDE;
            r_len       <= '0;
            r_closing   <= 1'b0;
            r_mis       <= 1'b0;
            r_err       <= ST_OK;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_closing   <= n_closing;
            r_mis       <= n_mis;
            r_err       <= n_err;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_count  <= n_count;
    end

    // Name character memory
    always_ff @(posedge i_clk) begin
        if (wr_char_en) begin
            mem_chars[wr_char_addr] <= i_ch;
        end
        r_char_rd <= mem_chars[rd_char_addr];
    end

    // Name length memory
    always_ff @(posedge i_clk) begin
        if (wr_len_en) begin
            mem_lens[wr_len_idx] <= r_len;
        end
        r_len_rd <= mem_lens[rd_top];
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_open_count = r_count;

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mtbc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_BYTES = 263;
    localparam int MIN_DOCS    = 48;
    localparam int GEN_LEVELS  = 8;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] open_count;
    } t_verdict;

    // Tracks tag nesting byte by byte and holds the verdicts still to come
    class tag_nest_tracker;
        t_phase              phase;
        logic [LEN_W-1:0]    name_len;
        bit                  closing;
        bit                  mismatch;
        logic [2:0]          err;
        logic [PTR_W-1:0]    depth;
        logic [7:0]          names [CHAR_N];
        logic [LEN_W-1:0]    lens [STACK_DEPTH];
        t_verdict            verdict_q [$];
        int unsigned         faults;

        function new();
            clear();
            faults = 0;
        endfunction

        function void clear();
            phase    = PH_OUTSIDE;
            name_len = '0;
            closing  = 1'b0;
            mismatch = 1'b0;
            err      = ST_OK;
            depth    = '0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        // Store an opening letter, or compare a closing one with the top entry
        function void add_letter(logic [7:0] c);
            int top;
            if (name_len >= MAX_NAME) begin
                err = ST_TOO_LONG;
                return;
            end
            if (closing) begin
                if (depth != 0) begin
                    top = int'(depth) - 1;
                    if (name_len < lens[top]) begin
                        if (names[top * MAX_NAME + int'(name_len)] != c)
                            mismatch = 1'b1;
                    end else begin
                        mismatch = 1'b1;
                    end
                end
            end else if (depth < STACK_DEPTH) begin
                names[int'(depth) * MAX_NAME + int'(name_len)] = c;
            end
            name_len++;
        endfunction

        // Apply the tag at its closing bracket: push, pop or latch an error
        function void end_tag();
            phase = PH_OUTSIDE;
            if (closing) begin
                if (depth == 0)
                    err = ST_EMPTY;
                else if (mismatch || name_len != lens[int'(depth) - 1])
                    err = ST_MISMATCH;
                else
                    depth--;
            end else begin
                if (depth >= STACK_DEPTH) begin
                    err = ST_OVERFLOW;
                end else begin
                    lens[int'(depth)] = name_len;
                    depth++;
                end
            end
        endfunction

        function void name_byte(logic [7:0] c);
            phase = PH_NAME;
            if (is_letter(c))
                add_letter(c);
            else if (c == CH_SPACE)
                phase = PH_ATTR;
            else if (c == CH_GT)
                end_tag();
        endfunction

        // Advance on one accepted request; queue a verdict on the last byte
        function void take_request(logic [7:0] c, logic l);
            t_verdict v;
            if (err == ST_OK) begin
                case (phase)
                    PH_OUTSIDE: begin
                        if (c == CH_LT) begin
                            phase    = PH_OPENED;
                            name_len = '0;
                            closing  = 1'b0;
                            mismatch = 1'b0;
                        end
                    end
                    PH_OPENED: begin
                        if (c == CH_SLASH) begin
                            closing = 1'b1;
                            phase   = PH_NAME;
                        end else begin
                            name_byte(c);
                        end
                    end
                    PH_NAME: name_byte(c);
                    default: begin
                        if (c == CH_GT)
                            end_tag();
                    end
                endcase
            end
            if (l) begin
                v.status     = (err == ST_OK && depth != 0) ? ST_UNCLOSED : err;
                v.open_count = depth;
                verdict_q.push_back(v);
                clear();
            end
        endfunction

        function void check_verdict(logic [2:0] status, logic [6:0] open_count);
            t_verdict v;
            if (verdict_q.size() == 0) begin
                $error("result with none pending: status %0d, open_count %0d",
                       status, open_count);
                faults++;
                return;
            end
            v = verdict_q.pop_front();
            if (status !== v.status) begin
                $error("status: expected %0d, got %0d", v.status, status);
                faults++;
            end
            if (open_count !== v.open_count) begin
                $error("open_count: expected %0d, got %0d", v.open_count, open_count);
                faults++;
            end
        endfunction

        function int outstanding();
            return verdict_q.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_ch        = 8'h00;
    logic       i_last      = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_status;
    logic [6:0] o_open_count;

    tag_nest_tracker tracker = new();

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned docs_sent  = 0;
    int unsigned cycle_count;

    logic [7:0] doc_q [$];
    logic [7:0] gen_name [GEN_LEVELS][40];
    int         gen_len [GEN_LEVELS];
    int         gen_depth;
    logic [7:0] specials [4] = '{CH_LT, CH_GT, CH_SLASH, CH_SPACE};

    markup_tag_balance_checker_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_ch         (i_ch),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_open_count (o_open_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Note each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            tracker.take_request(i_ch, i_last);
    end

    // Check accepted results and stall the output at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_verdict(o_status, o_open_count);
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Give up after a generous number of cycles
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    function logic [7:0] rand_letter();
        return 8'($urandom_range(1) ? 8'h41 + $urandom_range(25)
                                    : 8'h61 + $urandom_range(25));
    endfunction

    task add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            doc_q.push_back(s[i]);
    endtask

    // Hold one request until it is taken, idling beforehand at random
    task send_byte(input logic [7:0] c, input logic l);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        i_last     <= l;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task send_doc();
        for (int i = 0; i < doc_q.size(); i++) begin
            send_byte(doc_q[i], i == doc_q.size() - 1);
            bytes_sent++;
        end
        doc_q.delete();
        docs_sent++;
    endtask

    // Drop the valid and hold off until every verdict is back
    task drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Close the innermost generated tag; mode 1 adds a letter, 2 flips the case of
    // the first letter, 3 drops the name
    task emit_close(input int mode);
        logic [7:0] c;
        gen_depth--;
        doc_q.push_back(CH_LT);
        doc_q.push_back(CH_SLASH);
        for (int p = 0; p < gen_len[gen_depth]; p++) begin
            c = gen_name[gen_depth][p];
            if (mode == 2 && p == 0)
                c = c ^ 8'h20;
            if (mode != 3)
                doc_q.push_back(c);
        end
        if (mode == 1)
            doc_q.push_back(rand_letter());
        if ($urandom_range(99) < 10) begin
            doc_q.push_back(CH_SPACE);
            doc_q.push_back(rand_letter());
        end
        doc_q.push_back(CH_GT);
    endtask

    // Build one random document into doc_q
    task make_doc();
        int         kind;
        int         steps;
        int         cnt;
        int         cut;
        bit         broken;
        logic [7:0] b;
        kind = (docs_sent % 20 == 9) ? 70 : $urandom_range(99);
        if (kind < 60) begin
            // nested tags with random names, attributes and text, some of them broken
            gen_depth = 0;
            broken    = $urandom_range(99) < 30;
            steps     = $urandom_range(1, 14);
            repeat (steps) begin
                repeat ($urandom_range(2)) begin
                    b = 8'($urandom_range(255));
                    if (b == CH_LT)
                        b = CH_GT;
                    doc_q.push_back(b);
                end
                if (gen_depth > 0 && (gen_depth == GEN_LEVELS || $urandom_range(99) < 45)) begin
                    emit_close((broken && $urandom_range(99) < 30) ? $urandom_range(1, 3) : 0);
                end else begin
                    gen_len[gen_depth] = $urandom_range(6);
                    doc_q.push_back(CH_LT);
                    for (int p = 0; p < gen_len[gen_depth]; p++) begin
                        gen_name[gen_depth][p] = rand_letter();
                        doc_q.push_back(gen_name[gen_depth][p]);
                        if ($urandom_range(99) < 5)
                            doc_q.push_back(8'(8'h30 + $urandom_range(9)));
                    end
                    if ($urandom_range(99) < 25) begin
                        doc_q.push_back(CH_SPACE);
                        repeat ($urandom_range(6)) begin
                            b = 8'($urandom_range(255));
                            if (b == CH_GT)
                                b = CH_SLASH;
                            doc_q.push_back(b);
                        end
                    end
                    doc_q.push_back(CH_GT);
                    gen_depth++;
                end
            end
            if (!broken || $urandom_range(1)) begin
                while (gen_depth > 0)
                    emit_close(0);
            end
            if (broken && $urandom_range(1))
                add_text("</z>");
            repeat ($urandom_range(2))
                doc_q.push_back(rand_letter());
        end else if (kind < 70) begin
            // names around the length limit, on the opening or the closing side
            gen_depth  = 0;
            gen_len[0] = $urandom_range(MAX_NAME - 3, MAX_NAME + 1);
            doc_q.push_back(CH_LT);
            for (int p = 0; p < gen_len[0]; p++) begin
                gen_name[0][p] = rand_letter();
                doc_q.push_back(gen_name[0][p]);
            end
            doc_q.push_back(CH_GT);
            gen_depth = 1;
            if ($urandom_range(1))
                emit_close($urandom_range(1));
        end else if (kind < 75) begin
            // deep nesting around the stack limit
            cnt = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
            b   = $urandom_range(1) ? rand_letter() : 8'h00;
            repeat (cnt) begin
                doc_q.push_back(CH_LT);
                if (b != 8'h00)
                    doc_q.push_back(b);
                doc_q.push_back(CH_GT);
            end
            repeat ($urandom_range(STACK_DEPTH - 4, cnt)) begin
                doc_q.push_back(CH_LT);
                doc_q.push_back(CH_SLASH);
                if (b != 8'h00)
                    doc_q.push_back(b);
                doc_q.push_back(CH_GT);
            end
        end else begin
            // noise with plenty of markup characters
            repeat ($urandom_range(1, 20)) begin
                case ($urandom_range(3))
                    1: doc_q.push_back(specials[$urandom_range(3)]);
                    2: doc_q.push_back(rand_letter());
                    default: doc_q.push_back(8'($urandom_range(255)));
                endcase
            end
        end
        // cut some documents short, often in the middle of a tag
        if (doc_q.size() > 1 && $urandom_range(99) < 8) begin
            cut = $urandom_range(1, doc_q.size() - 1);
            while (doc_q.size() > cut)
                void'(doc_q.pop_back());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed documents: empty names, close on empty, unclosed, mismatch,
        // unterminated tag and the byte extremes
        add_text("<></>");
        send_doc();
        add_text("</>");
        send_doc();
        add_text("<a>");
        send_doc();
        add_text("<a></b>");
        send_doc();
        add_text("<ab");
        send_doc();
        doc_q.push_back(8'h00);
        send_doc();
        doc_q.push_back(8'hFF);
        send_doc();

        // Random documents over four phases of input idling and output stalling
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            while (bytes_sent < (ph + 1) * PHASE_BYTES || (ph == 3 && docs_sent < MIN_DOCS)) begin
                make_doc();
                send_doc();
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (tracker.faults == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
